>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define KVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define KVS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/kvs_pkg.sv
// Types and constants of the keyframe sampler.
`default_nettype none

package kvs_pkg;

  localparam int STAMP_W = 32;
  localparam int COORD_W = 32;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int FRAC_W  = 16;

  typedef logic [STAMP_W-1:0]        stamp_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SLOT_W-1:0]         slot_t;
  typedef logic [COUNT_W-1:0]        count_t;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

endpackage

`default_nettype wire

>>> rtl/kvs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module kvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/keyframe_vec3_sampler.sv
// Keyframe table with a linear-interpolation sampler for Q16.16 vectors.
`default_nettype none

// A load word writes one keyframe (stamp and x/y/z) into two synchronous RAMs
// in the cycle it is accepted and gives no result. A sample word scans the
// stamp RAM one entry per cycle from slot 1 upward until a stamp lies beyond
// the sample time, reads both keys of that segment, forms the Q0.16 blend
// factor in a restoring divider and blends x, y and z through one shared
// multiplier. The divider is skipped when the factor is known to be zero; the
// input is held off until the result goes to the output register. After a load
// the input stays open. The result sits in an output register, so the next
// word is taken while a result still waits. Table entries are undefined until
// loaded; there is no clearing pass after reset. The user writes key_count
// through the cfg port only while the block is idle; the block itself does not
// enforce this. 0 acts as 1 and values above MAX_KEYS act as MAX_KEYS.

module keyframe_vec3_sampler #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration: key_count
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire kvs_pkg::count_t  cfg_data,
  // input words
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             req_type,
  input  wire kvs_pkg::slot_t   key_slot,
  input  wire kvs_pkg::stamp_t  key_stamp,
  input  wire kvs_pkg::coord_t  key_x,
  input  wire kvs_pkg::coord_t  key_y,
  input  wire kvs_pkg::coord_t  key_z,
  input  wire kvs_pkg::stamp_t  sample_time,
  // result words
  output logic                  out_valid,
  input  wire logic             out_ready,
  output kvs_pkg::coord_t       out_x,
  output kvs_pkg::coord_t       out_y,
  output kvs_pkg::coord_t       out_z,
  output kvs_pkg::slot_t        segment
);

  import kvs_pkg::*;

  localparam int AW      = $clog2(MAX_KEYS);
  localparam int CW      = $clog2(MAX_KEYS + 1);
  localparam int POINT_W = 3 * COORD_W;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + FRAC_W + 1;
  localparam int SUM_W   = PROD_W - FRAC_W;
  localparam int DIV_CW  = $clog2(FRAC_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_LO,
    ST_RD_HI,
    ST_CAPTURE,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  state_t state;

  count_t key_count;

  // memories
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  stamp_t             stamp_rdata;
  logic [POINT_W-1:0] point_rdata;

  // query context
  stamp_t             t;
  logic [CW-1:0]      n;
  logic [CW-1:0]      n_in;
  logic [CW-1:0]      issue_idx;
  logic               pend;
  logic [AW-1:0]      pend_idx;
  logic [AW-1:0]      p0;
  logic [AW-1:0]      p1;
  stamp_t             lo;

  // divider
  logic [STAMP_W-1:0] rem;
  logic [STAMP_W-1:0] den;
  logic [FRAC_W-1:0]  quo;
  logic [DIV_CW-1:0]  div_cnt;
  logic [STAMP_W:0]   rem2;
  logic               rem_ge;

  // blend
  coord_t                   a_c    [0:2];
  logic signed [DIFF_W-1:0] diff_c [0:2];
  coord_t                   res_c  [0:2];
  logic signed [PROD_W-1:0] prod;
  logic [1:0]               comp;
  logic signed [SUM_W-1:0]  sum;

  logic accept;
  logic hi_gt_lo_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;

  assign mem_we    = accept && (req_type == REQ_LOAD) && (int'(key_slot) < MAX_KEYS);
  assign mem_waddr = AW'(key_slot);

  always_comb begin
    unique case (state)
      ST_SCAN:  mem_raddr = issue_idx[AW-1:0];
      ST_RD_HI: mem_raddr = p1;
      default:  mem_raddr = p0;
    endcase
  end

  always_comb begin
    if (key_count == '0) begin
      n_in = CW'(1);
    end else if (int'(key_count) > MAX_KEYS) begin
      n_in = CW'(MAX_KEYS);
    end else begin
      n_in = CW'(key_count);
    end
  end

  kvs_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_KEYS)) u_stamp_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (key_stamp),
    .raddr (mem_raddr),
    .rdata (stamp_rdata)
  );

  kvs_ram #(.WIDTH(POINT_W), .DEPTH(MAX_KEYS)) u_point_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({key_x, key_y, key_z}),
    .raddr (mem_raddr),
    .rdata (point_rdata)
  );

  // one restoring step: remainder stays below den throughout
  assign rem2   = {rem, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, den});

  // factor is non-zero only inside a real segment with t past its lower stamp
  assign hi_gt_lo_ok = (p1 != p0) && (t > lo) && (stamp_rdata > lo);

  assign sum = SUM_W'(a_c[comp]) + prod[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      key_count <= COUNT_W'(1);
      pend      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        key_count <= cfg_data;
      end
      // ST_DONE reloads the output register itself
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept && (req_type == REQ_SAMPLE)) begin
            t         <= sample_time;
            n         <= n_in;
            issue_idx <= CW'(1);
            pend      <= 1'b0;
            state     <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (pend && (t < stamp_rdata)) begin
            p0    <= AW'(pend_idx - AW'(1));
            state <= ST_RD_LO;
          end else if (issue_idx == n) begin
            p0    <= AW'(n - CW'(1));
            state <= ST_RD_LO;
          end else begin
            pend      <= 1'b1;
            pend_idx  <= issue_idx[AW-1:0];
            issue_idx <= issue_idx + CW'(1);
          end
        end

        ST_RD_LO: begin
          // p0 is on the read port this cycle
          if ((CW'(p0) + CW'(1)) < n) begin
            p1 <= AW'(p0 + AW'(1));
          end else begin
            p1 <= p0;
          end
          state <= ST_RD_HI;
        end

        ST_RD_HI: begin
          lo     <= stamp_rdata;
          a_c[0] <= point_rdata[3*COORD_W-1:2*COORD_W];
          a_c[1] <= point_rdata[2*COORD_W-1:COORD_W];
          a_c[2] <= point_rdata[COORD_W-1:0];
          state  <= ST_CAPTURE;
        end

        ST_CAPTURE: begin
          diff_c[0] <= $signed({point_rdata[3*COORD_W-1], point_rdata[3*COORD_W-1:2*COORD_W]})
                       - $signed({a_c[0][COORD_W-1], a_c[0]});
          diff_c[1] <= $signed({point_rdata[2*COORD_W-1], point_rdata[2*COORD_W-1:COORD_W]})
                       - $signed({a_c[1][COORD_W-1], a_c[1]});
          diff_c[2] <= $signed({point_rdata[COORD_W-1], point_rdata[COORD_W-1:0]})
                       - $signed({a_c[2][COORD_W-1], a_c[2]});
          rem     <= t - lo;
          den     <= stamp_rdata - lo;
          div_cnt <= '0;
          comp    <= 2'd0;
          if (hi_gt_lo_ok) begin
            state <= ST_DIV;
          end else begin
            quo   <= '0;
            state <= ST_MUL;
          end
        end

        ST_DIV: begin
          if (rem_ge) begin
            rem <= STAMP_W'(rem2 - {1'b0, den});
          end else begin
            rem <= rem2[STAMP_W-1:0];
          end
          quo     <= {quo[FRAC_W-2:0], rem_ge};
          div_cnt <= div_cnt + DIV_CW'(1);
          if (div_cnt == DIV_CW'(FRAC_W - 1)) begin
            state <= ST_MUL;
          end
        end

        ST_MUL: begin
          prod  <= diff_c[comp] * $signed({1'b0, quo});
          state <= ST_ADD;
        end

        ST_ADD: begin
          res_c[comp] <= sum[COORD_W-1:0];
          comp        <= comp + 2'd1;
          if (comp == 2'd2) begin
            state <= ST_DONE;
          end else begin
            state <= ST_MUL;
          end
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_x     <= res_c[0];
            out_y     <= res_c[1];
            out_z     <= res_c[2];
            segment   <= SLOT_W'(p0);
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/kvs_checker.sv
// Port-level checks for the keyframe sampler, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module kvs_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            req_type,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire kvs_pkg::coord_t out_x,
  input wire kvs_pkg::coord_t out_y,
  input wire kvs_pkg::coord_t out_z,
  input wire kvs_pkg::slot_t  segment
);

  import kvs_pkg::*;

  `KVS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")
  `KVS_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(segment), "stalled result changed")
  `KVS_ASSERT(a_load_silent, in_valid && in_ready && req_type == REQ_LOAD && !out_valid |=> !out_valid, "load produced a result")
  `KVS_ASSERT(a_sample_busy, in_valid && in_ready && req_type == REQ_SAMPLE |=> !in_ready, "input open during a sample")
  `KVS_ASSERT_RST(a_reset_empty, rst |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind keyframe_vec3_sampler kvs_checker u_kvs_checker (.*);

`default_nettype wire
